@@ src/mfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Maze router package
// Shared types and constants for the flood-fill maze router.
// ----------------------------------------------------------------------------
`default_nettype none

package mfr_pkg;

   localparam int GRID_SIDE_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 256;
   localparam int CELL_COUNT      = 256;
   localparam int CELL_BITS       = 8;
   localparam logic [7:0] DIST_UNDEF = 8'd255;
   localparam logic [7:0] DIST_MAX   = 8'd254;

   localparam logic [0:0] CSR_GOAL_X = 1'b0;
   localparam logic [0:0] CSR_GOAL_Y = 1'b1;

   localparam logic [1:0] TURN_FORWARD = 2'd0;
   localparam logic [1:0] TURN_RIGHT   = 2'd1;
   localparam logic [1:0] TURN_LEFT    = 2'd2;
   localparam logic [1:0] TURN_STAY    = 2'd3;

   typedef struct packed {
      logic [3:0] cell_x;
      logic [3:0] cell_y;
      logic [1:0] heading;
      logic       sense_left;
      logic       sense_front;
      logic       sense_right;
   } req_type;

   typedef struct packed {
      logic [3:0] next_x;
      logic [3:0] next_y;
      logic [1:0] turn;
      logic       at_goal;
      logic [7:0] distance;
   } rsp_type;

endpackage

`default_nettype wire

@@ src/mfr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ src/maze_flood_fill_router.sv @@
// ----------------------------------------------------------------------------
// Maze flood-fill router
// Records sensed walls, refloods the maze breadth-first and picks a move.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake     | payload
//   req     | in        | valid / stall | req_type: cell, heading, walls
//   rsp     | out       | valid / stall | rsp_type: next cell, turn, distance
//   csr     | in        | valid / ready | index 0 goal_x, index 1 goal_y
//
// One item runs through a sequencer that works on the memories only, so
// its length is set by the single memory ports: after reset the wall and
// distance stores are swept once. Per item: the wall updates, a distance
// clear sweep, the seeding of the four goal cells, then per queued cell
// a pop and its reads plus a probe of each open neighbour's distance and
// a skip of each blocked side, then the move choice.
// The result register holds a finished result while rsp_stall is high; the
// next request is then accepted and waits in the sequencer's result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module maze_flood_fill_router
   import mfr_pkg::*;
#(
   parameter int GRID_SIDE   = GRID_SIDE_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire req_type    req_data,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      rsp_type    rsp_data,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [0:0] csr_index,
   input  wire logic [3:0] csr_data
);

   localparam int QA = $clog2(QUEUE_DEPTH);
   localparam logic [3:0] TOP  = 4'(GRID_SIDE - 1);
   localparam logic [3:0] GTOP = 4'(GRID_SIDE - 2);

   // Sequencer states.
   localparam logic [4:0] ST_INIT   = 5'd0;  // reset sweep of both stores
   localparam logic [4:0] ST_IDLE   = 5'd1;
   localparam logic [4:0] ST_WRD    = 5'd2;  // read a wall entry
   localparam logic [4:0] ST_WWR    = 5'd4;  // write merged wall entry
   localparam logic [4:0] ST_CLR    = 5'd5;  // distance clear sweep
   localparam logic [4:0] ST_SEED   = 5'd6;  // seed goal cells
   localparam logic [4:0] ST_POP    = 5'd7;  // pop a queue entry
   localparam logic [4:0] ST_PRD    = 5'd9;  // read wall and distance of cell
   localparam logic [4:0] ST_PWAIT2 = 5'd10;
   localparam logic [4:0] ST_NRD    = 5'd11; // read neighbour distance
   localparam logic [4:0] ST_NCHK   = 5'd13;
   localparam logic [4:0] ST_CRD    = 5'd14; // choice: read current cell
   localparam logic [4:0] ST_CWAIT  = 5'd15;
   localparam logic [4:0] ST_CNRD   = 5'd16; // choice: read a neighbour
   localparam logic [4:0] ST_CNCHK  = 5'd18;
   localparam logic [4:0] ST_DONE   = 5'd19;

   logic [4:0] state_ff, state_in;
   logic [3:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [7:0] cnt_ff, cnt_in;
   req_type    req_ff, req_in;
   logic [1:0] k_ff, k_in;          // wall side or direction counter
   logic [3:0] x_ff, x_in, y_ff, y_in;
   logic [3:0] cw_ff, cw_in;         // wall bits of the cell being expanded
   logic [7:0] nd_ff, nd_in;
   logic [QA-1:0] qhead_ff, qhead_in;
   logic [QA:0]   qcount_ff, qcount_in;
   logic [7:0] best_ff, best_in;
   logic [3:0] bx_ff, bx_in, by_ff, by_in;
   logic [1:0] bturn_ff, bturn_in;
   logic [7:0] here_ff, here_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   // Memory ports.
   logic       w_we;
   logic [7:0] w_wa, w_ra;
   logic [3:0] w_wd, w_rd;
   logic       d_we;
   logic [7:0] d_wa, d_ra;
   logic [7:0] d_wd, d_rd;
   logic          q_we;
   logic [QA-1:0] q_wa, q_ra;
   logic [7:0]    q_wd, q_rd;

   mfr_ram #(.WIDTH(4), .DEPTH(CELL_COUNT)) u_wall (
      .clock, .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
      .rd_addr(w_ra), .rd_data(w_rd));
   mfr_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_dist (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra), .rd_data(d_rd));
   mfr_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));

   function automatic logic [3:0] sat4(input logic [3:0] v, input logic [3:0] top);
      sat4 = (v > top) ? top : v;
   endfunction

   // Neighbour in absolute direction d; ok is low outside the grid.
   function automatic logic [8:0] nbr(input logic [3:0] x, input logic [3:0] y,
                                      input logic [1:0] d);
      logic       ok;
      logic [3:0] nx, ny;
      ok = 1'b1;
      nx = x;
      ny = y;
      case (d)
         2'd0: begin
            ok = (y != TOP);
            ny = y + 4'd1;
         end
         2'd1: begin
            ok = (x != TOP);
            nx = x + 4'd1;
         end
         2'd2: begin
            ok = (y != 4'd0);
            ny = y - 4'd1;
         end
         default: begin
            ok = (x != 4'd0);
            nx = x - 4'd1;
         end
      endcase
      nbr = {ok, nx, ny};
   endfunction

   function automatic logic [3:0] boundary(input logic [3:0] x, input logic [3:0] y);
      boundary = {x == 4'd0, y == 4'd0, x == TOP, y == TOP};
   endfunction

   // Goal block check for a cell.
   function automatic logic in_goal(input logic [3:0] x, input logic [3:0] y,
                                    input logic [3:0] gx, input logic [3:0] gy);
      in_goal = (x == gx || x == gx + 4'd1) && (y == gy || y == gy + 4'd1);
   endfunction

   logic [3:0] gxs, gys, cx, cy;
   logic [1:0] rel_dir, side_dir;
   logic       side_on;
   logic [8:0] nb;
   logic [QA-1:0] qtail;
   logic [1:0] turn_of_k;
   logic [3:0] sweep_x, sweep_y;

   assign gxs = sat4(goal_x_ff, GTOP);
   assign gys = sat4(goal_y_ff, GTOP);
   assign cx  = sat4(req_ff.cell_x, TOP);
   assign cy  = sat4(req_ff.cell_y, TOP);
   assign qtail = qhead_ff + qcount_ff[QA-1:0];
   assign sweep_x = cnt_ff[7:4];
   assign sweep_y = cnt_ff[3:0];

   // k = 0 left, 1 front, 2 right as relative direction offsets.
   always_comb begin
      case (k_ff)
         2'd0: begin
            rel_dir   = req_ff.heading + 2'd3;
            side_on   = req_ff.sense_left;
            turn_of_k = TURN_LEFT;
         end
         2'd1: begin
            rel_dir   = req_ff.heading;
            side_on   = req_ff.sense_front;
            turn_of_k = TURN_FORWARD;
         end
         default: begin
            rel_dir   = req_ff.heading + 2'd1;
            side_on   = req_ff.sense_right;
            turn_of_k = TURN_RIGHT;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      cnt_in = cnt_ff;
      req_in = req_ff;
      k_in = k_ff;
      x_in = x_ff;
      y_in = y_ff;
      cw_in = cw_ff;
      nd_in = nd_ff;
      qhead_in = qhead_ff;
      qcount_in = qcount_ff;
      best_in = best_ff;
      bx_in = bx_ff;
      by_in = by_ff;
      bturn_in = bturn_ff;
      here_in = here_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      side_dir = 2'd0;
      nb = 9'd0;
      w_we = 1'b0; w_wa = 8'd0; w_wd = 4'd0; w_ra = 8'd0;
      d_we = 1'b0; d_wa = 8'd0; d_wd = 8'd0; d_ra = 8'd0;
      q_we = 1'b0; q_wa = '0; q_wd = 8'd0; q_ra = qhead_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GOAL_X: goal_x_in = csr_data;
            default:    goal_y_in = csr_data;
         endcase
      end

      case (state_ff)
         ST_INIT: begin
            w_we = 1'b1;
            w_wa = cnt_ff[7:0];
            w_wd = boundary(sweep_x, sweep_y);
            d_we = 1'b1;
            d_wa = cnt_ff[7:0];
            d_wd = in_goal(sweep_x, sweep_y, gxs, gys) ? 8'd0 : DIST_UNDEF;
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff[7:0] == 8'd255) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               k_in = 2'd0;
               cw_in = 4'd0; // phase: 0 own cell, 1 neighbour
               state_in = ST_WRD;
            end
         end
         // Wall update: for each sensed side, own cell then the neighbour.
         ST_WRD: begin
            side_dir = rel_dir;
            nb = nbr(cx, cy, side_dir);
            if (k_ff == 2'd3) begin
               cnt_in = 8'd0;
               state_in = ST_CLR;
            end else if (!side_on || (cw_ff[0] && !nb[8])) begin
               k_in = k_ff + 2'd1;
               cw_in = 4'd0;
            end else begin
               w_ra = cw_ff[0] ? nb[7:0] : {cx, cy};
               state_in = ST_WWR;
            end
         end
         ST_WWR: begin
            side_dir = rel_dir;
            nb = nbr(cx, cy, side_dir);
            w_we = 1'b1;
            if (cw_ff[0]) begin
               w_wa = nb[7:0];
               w_wd = w_rd | (4'd1 << (side_dir + 2'd2));
               k_in = k_ff + 2'd1;
               cw_in = 4'd0;
            end else begin
               w_wa = {cx, cy};
               w_wd = w_rd | (4'd1 << side_dir);
               cw_in = 4'd1;
            end
            state_in = ST_WRD;
         end
         ST_CLR: begin
            d_we = 1'b1;
            d_wa = cnt_ff[7:0];
            d_wd = DIST_UNDEF;
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff[7:0] == 8'd255) begin
               cnt_in = 8'd0;
               qhead_in = '0;
               qcount_in = '0;
               state_in = ST_SEED;
            end
         end
         // Four goal cells, one per cycle, each written and queued in the
         // order lower left, lower right, upper left, upper right.
         ST_SEED: begin
            d_we = 1'b1;
            d_wa = {gxs + {3'd0, cnt_ff[0]}, gys + {3'd0, cnt_ff[1]}};
            d_wd = 8'd0;
            q_we = 1'b1;
            q_wa = cnt_ff[QA-1:0];
            q_wd = d_wa;
            qcount_in = qcount_ff + (QA+1)'(1);
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (qcount_ff == '0) begin
               k_in = 2'd0;
               state_in = ST_CRD;
            end else begin
               q_ra = qhead_ff;
               qhead_in = qhead_ff + QA'(1);
               qcount_in = qcount_ff - (QA+1)'(1);
               state_in = ST_PRD;
            end
         end
         ST_PRD: begin
            x_in = q_rd[7:4];
            y_in = q_rd[3:0];
            w_ra = q_rd;
            d_ra = q_rd;
            state_in = ST_PWAIT2;
         end
         ST_PWAIT2: begin
            cw_in = w_rd;
            nd_in = (d_rd >= DIST_MAX) ? DIST_MAX : d_rd + 8'd1;
            k_in = 2'd0;
            state_in = ST_NRD;
         end
         ST_NRD: begin
            nb = nbr(x_ff, y_ff, k_ff);
            if (cw_ff[k_ff] || !nb[8]) begin
               k_in = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  state_in = ST_POP;
               end
            end else begin
               d_ra = nb[7:0];
               state_in = ST_NCHK;
            end
         end
         ST_NCHK: begin
            nb = nbr(x_ff, y_ff, k_ff);
            if (d_rd == DIST_UNDEF) begin
               d_we = 1'b1;
               d_wa = nb[7:0];
               d_wd = nd_ff;
               if (qcount_ff != (QA+1)'(QUEUE_DEPTH)) begin
                  q_we = 1'b1;
                  q_wa = qtail;
                  q_wd = nb[7:0];
                  qcount_in = qcount_ff + (QA+1)'(1);
               end
            end
            k_in = k_ff + 2'd1;
            state_in = (k_ff == 2'd3) ? ST_POP : ST_NRD;
         end
         ST_CRD: begin
            w_ra = {cx, cy};
            d_ra = {cx, cy};
            state_in = ST_CWAIT;
         end
         ST_CWAIT: begin
            cw_in = w_rd;
            here_in = d_rd;
            best_in = DIST_UNDEF;
            bx_in = cx;
            by_in = cy;
            bturn_in = TURN_STAY;
            k_in = 2'd0;
            state_in = ST_CNRD;
         end
         ST_CNRD: begin
            nb = nbr(cx, cy, rel_dir);
            if (k_ff == 2'd3) begin
               state_in = ST_DONE;
            end else if (cw_ff[rel_dir] || !nb[8]) begin
               k_in = k_ff + 2'd1;
            end else begin
               d_ra = nb[7:0];
               state_in = ST_CNCHK;
            end
         end
         ST_CNCHK: begin
            nb = nbr(cx, cy, rel_dir);
            if (d_rd != DIST_UNDEF && d_rd < best_ff) begin
               best_in = d_rd;
               bx_in = nb[7:4];
               by_in = nb[3:0];
               bturn_in = turn_of_k;
            end
            k_in = k_ff + 2'd1;
            state_in = ST_CNRD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.next_x = bx_ff;
               rsp_in.next_y = by_ff;
               rsp_in.turn = bturn_ff;
               rsp_in.at_goal = (here_ff == 8'd0);
               rsp_in.distance = here_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         goal_x_ff <= 4'd7;
         goal_y_ff <= 4'd7;
         cnt_ff <= 8'd0;
         qhead_ff <= '0;
         qcount_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         goal_x_ff <= goal_x_in;
         goal_y_ff <= goal_y_in;
         cnt_ff <= cnt_in;
         qhead_ff <= qhead_in;
         qcount_ff <= qcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      k_ff <= k_in;
      x_ff <= x_in;
      y_ff <= y_in;
      cw_ff <= cw_in;
      nd_ff <= nd_in;
      best_ff <= best_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
      bturn_ff <= bturn_in;
      here_ff <= here_in;
      rsp_ff <= rsp_in;
   end

`ifndef ASSERT_OFF
   // The queue never holds more than its depth.
   a_qcount: assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= (QA+1)'(QUEUE_DEPTH))
      else $error("queue overfilled");
   // A result appears only on leaving the final sequencer state.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result without finished item");
   // A reported goal arrival always carries distance zero.
   a_goal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.at_goal == (rsp_ff.distance == 8'd0)))
      else $error("at_goal inconsistent");
   // A stalled result stays valid and unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
